@@ rtl/three_rotor_reflector_cipher_top_assert.svh @@
// Assertion macros for the three-rotor cipher checker.
// Used by trrc_checker; expects i_clk and i_rst_n in scope.
`ifndef THREE_ROTOR_REFLECTOR_CIPHER_TOP_ASSERT_SVH
`define THREE_ROTOR_REFLECTOR_CIPHER_TOP_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define TRRC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("trrc assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define TRRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("trrc assertion failed");

`endif

@@ rtl/trrc_pkg.sv @@
// Shared types, codes and wiring tables for the three-rotor cipher.
// No dependencies; imported by every rtl module of the block.
package trrc_pkg;

    localparam int unsigned Alpha     = 26;
    localparam int unsigned NumRotors = 3;
    localparam int unsigned LetterW   = 5;
    localparam int unsigned CfgIdxW   = 3;

    typedef logic [LetterW-1:0] t_letter;
    typedef t_letter [NumRotors-1:0] t_rotor_set;
    typedef logic [1:0] t_rotor_idx;

    // input opcodes
    localparam logic OpEncode = 1'b0;
    localparam logic OpReload = 1'b1;

    // config register indexes
    localparam logic [CfgIdxW-1:0] CfgStartOne   = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgStartTwo   = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgStartThree = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgNotchOne   = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgNotchTwo   = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgNotchThree = 3'd5;

    // marks "letter not found in wiring"
    localparam t_letter NoLetter = t_letter'(Alpha);

    // element 0 is rotor one
    localparam t_rotor_set StartReset = {5'd10, 5'd23, 5'd1};
    localparam t_rotor_set PosReset   = {5'd20, 5'd8, 5'd22};
    localparam t_letter NotchOneReset = 5'd2;
    localparam t_letter NotchTwoReset = 5'd9;

    localparam t_letter WireTab [NumRotors][Alpha] = '{
        '{5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25,
          5'd13, 5'd19, 5'd14, 5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18,
          5'd15, 5'd0, 5'd8, 5'd1, 5'd17, 5'd2, 5'd9},
        '{5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1,
          5'd11, 5'd7, 5'd22, 5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25,
          5'd13, 5'd15, 5'd24, 5'd5, 5'd21, 5'd14, 5'd4},
        '{5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19,
          5'd23, 5'd21, 5'd25, 5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6,
          5'd0, 5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14}
    };

    localparam t_letter InvTab [NumRotors][Alpha] = '{
        '{5'd20, 5'd22, 5'd24, 5'd6, 5'd0, 5'd3, 5'd5, 5'd15, 5'd21, 5'd25,
          5'd1, 5'd4, 5'd2, 5'd10, 5'd12, 5'd19, 5'd7, 5'd23, 5'd18,
          5'd11, 5'd17, 5'd8, 5'd13, 5'd16, 5'd14, 5'd9},
        '{5'd0, 5'd9, 5'd15, 5'd2, 5'd25, 5'd22, 5'd17, 5'd11, 5'd5, 5'd1,
          5'd3, 5'd10, 5'd14, 5'd19, 5'd24, 5'd20, 5'd16, 5'd6, 5'd4,
          5'd13, 5'd7, 5'd23, 5'd12, 5'd8, 5'd21, 5'd18},
        '{5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd16, 5'd4,
          5'd20, 5'd5, 5'd21, 5'd13, 5'd25, 5'd7, 5'd24, 5'd8, 5'd23,
          5'd9, 5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12}
    };

    localparam t_letter ReflTab [Alpha] = '{
        5'd5, 5'd21, 5'd15, 5'd9, 5'd8, 5'd0, 5'd14, 5'd24, 5'd4, 5'd3,
        5'd17, 5'd25, 5'd23, 5'd22, 5'd6, 5'd2, 5'd19, 5'd10, 5'd20,
        5'd16, 5'd18, 5'd1, 5'd13, 5'd12, 5'd7, 5'd11
    };

    // x must be 0..25
    function automatic t_letter wire_fwd(t_rotor_idx r, t_letter x);
        return WireTab[r][x];
    endfunction

    // returns NoLetter for codes outside the alphabet
    function automatic t_letter wire_inv(t_rotor_idx r, t_letter v);
        if (v >= t_letter'(Alpha)) begin
            return NoLetter;
        end
        return InvTab[r][v];
    endfunction

    function automatic t_letter reflect(t_letter x);
        return ReflTab[x];
    endfunction

    // (a + b) mod 26, both operands 0..25
    function automatic t_letter mod_add(t_letter a, t_letter b);
        logic [LetterW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (LetterW+1)'(Alpha)) begin
            s = s - (LetterW+1)'(Alpha);
        end
        return s[LetterW-1:0];
    endfunction

    // (a - b) mod 26, both operands 0..25
    function automatic t_letter mod_sub(t_letter a, t_letter b);
        logic [LetterW:0] s;
        s = {1'b0, a} + (LetterW+1)'(Alpha) - {1'b0, b};
        if (s >= (LetterW+1)'(Alpha)) begin
            s = s - (LetterW+1)'(Alpha);
        end
        return s[LetterW-1:0];
    endfunction

endpackage

@@ rtl/trrc_step.sv @@
// Rotor position state, config registers and stepping/reload logic.
// Depends on trrc_pkg.
module trrc_step (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [trrc_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  trrc_pkg::t_letter                 i_cfg_data,
    input  logic                              i_step,
    input  logic                              i_reload,
    output trrc_pkg::t_rotor_set              o_pos_next
);
    import trrc_pkg::*;

    t_rotor_set r_start;
    t_letter    r_notch_one;
    t_letter    r_notch_two;
    t_rotor_set r_pos;
    t_rotor_set n_pos;
    logic       carry_one;
    logic       carry_two;
    t_letter    reload_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= StartReset;
            r_notch_one <= NotchOneReset;
            r_notch_two <= NotchTwoReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgStartOne:   r_start[0]  <= i_cfg_data;
                CfgStartTwo:   r_start[1]  <= i_cfg_data;
                CfgStartThree: r_start[2]  <= i_cfg_data;
                CfgNotchOne:   r_notch_one <= i_cfg_data;
                CfgNotchTwo:   r_notch_two <= i_cfg_data;
                default: begin
                    // rotor three notch has no effect; unknown indexes ignored
                end
            endcase
        end
    end

    // carry is judged on positions before the step
    assign carry_one = (wire_fwd(2'd0, r_pos[0]) == r_notch_one);
    assign carry_two = carry_one && (wire_fwd(2'd1, r_pos[1]) == r_notch_two);

    always_comb begin
        n_pos      = r_pos;
        reload_pos = NoLetter;
        if (i_reload) begin
            for (int r = 0; r < NumRotors; r++) begin
                reload_pos = wire_inv(t_rotor_idx'(r), r_start[r]);
                if (reload_pos != NoLetter) begin
                    n_pos[r] = reload_pos;
                end
            end
        end else if (i_step) begin
            n_pos[0] = mod_add(r_pos[0], t_letter'(1));
            if (carry_one) begin
                n_pos[1] = mod_add(r_pos[1], t_letter'(1));
            end
            if (carry_two) begin
                n_pos[2] = mod_add(r_pos[2], t_letter'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= PosReset;
        end else begin
            r_pos <= n_pos;
        end
    end

    assign o_pos_next = n_pos;

endmodule

@@ rtl/trrc_subst.sv @@
// Substitution path: three rotors forward, reflector, three rotors back.
// Depends on trrc_pkg.
module trrc_subst (
    input  trrc_pkg::t_letter    i_letter,
    input  trrc_pkg::t_rotor_set i_pos,
    output trrc_pkg::t_letter    o_letter
);
    import trrc_pkg::*;

    t_letter x;

    always_comb begin
        x = i_letter;
        for (int r = 0; r < NumRotors; r++) begin
            x = wire_fwd(t_rotor_idx'(r), mod_add(x, i_pos[r]));
        end
        x = reflect(x);
        for (int r = NumRotors - 1; r >= 0; r--) begin
            x = mod_sub(wire_inv(t_rotor_idx'(r), x), i_pos[r]);
        end
    end

    assign o_letter = x;

endmodule

@@ rtl/three_rotor_reflector_cipher_top.sv @@
// Top level of the three-rotor reflector cipher.
// Depends on trrc_pkg, trrc_step and trrc_subst.

// Three-rotor substitution cipher with fixed reflector on letters A=0..Z=25.
// One transaction per clock is accepted and one result per clock delivered
// while the output is not stalled; an encode transaction's result passes
// through the stage-1 and output registers (stepping happens at acceptance,
// the seven table lookups of the substitution sit between the stage-1
// register and the output register). A reload transaction (opcode 1) moves
// each rotor to the place of its start letter and returns nothing; an encode
// of a code 26..31 returns nothing and leaves the rotors alone. Input stall
// is raised only when both the stage-1 and output registers are full and
// the output is stalled. Config registers (index 0..2 start letters, 3..5
// notch letters) may only be written while no transaction is in flight.
module three_rotor_reflector_cipher_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [trrc_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  trrc_pkg::t_letter                 i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_opcode,
    input  trrc_pkg::t_letter                 i_letter,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output trrc_pkg::t_letter                 o_cipher_letter
);
    import trrc_pkg::*;

    logic       in_accept;
    logic       do_step;
    logic       do_reload;
    logic       out_ready;
    logic       s1_ready;
    t_rotor_set pos_next;
    t_letter    subst_letter;

    // stage 1: letter plus the positions it is ciphered under
    logic       r_s1_vld;
    logic       n_s1_vld;
    t_letter    r_s1_letter;
    t_rotor_set r_s1_pos;

    // output register
    logic       r_out_vld;
    logic       n_out_vld;
    t_letter    r_out_letter;

    // handshake: each stage moves when the one after it can take data
    assign out_ready  = !r_out_vld || !i_out_stall;
    assign s1_ready   = !r_s1_vld || out_ready;
    assign o_in_stall = !s1_ready;
    assign in_accept  = i_in_valid && s1_ready;

    // only in-range encodes step the rotors and produce a result
    assign do_step   = in_accept && (i_opcode == OpEncode) &&
                       (i_letter < t_letter'(Alpha));
    assign do_reload = in_accept && (i_opcode == OpReload);

    trrc_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (do_step),
        .i_reload    (do_reload),
        .o_pos_next  (pos_next)
    );

    trrc_subst u_subst (
        .i_letter (r_s1_letter),
        .i_pos    (r_s1_pos),
        .o_letter (subst_letter)
    );

    always_comb begin
        n_s1_vld  = r_s1_vld;
        n_out_vld = r_out_vld;
        if (s1_ready) begin
            n_s1_vld = do_step;
        end
        if (out_ready) begin
            n_out_vld = r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (do_step) begin
            r_s1_letter <= i_letter;
            r_s1_pos    <= pos_next;
        end
        if (out_ready && r_s1_vld) begin
            r_out_letter <= subst_letter;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_cipher_letter = r_out_letter;

endmodule

@@ rtl/trrc_checker.sv @@
// Port-level assertion checker for the three-rotor cipher, bound to the top.
// Depends on trrc_pkg and three_rotor_reflector_cipher_top_assert.svh.
`include "three_rotor_reflector_cipher_top_assert.svh"

module trrc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              i_opcode,
    input trrc_pkg::t_letter i_letter,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input trrc_pkg::t_letter o_cipher_letter
);
    import trrc_pkg::*;

    logic    enc_accept;
    logic    echo_free;
    t_letter r_letter_q1;
    t_letter r_letter_q2;

    // in-range encode transaction taken this cycle
    assign enc_accept = i_in_valid && !o_in_stall && (i_opcode == OpEncode) &&
                        (i_letter < t_letter'(Alpha));

    // input letter history, delayed through r_letter_q1 and r_letter_q2
    always_ff @(posedge i_clk) begin
        r_letter_q1 <= i_letter;
        r_letter_q2 <= r_letter_q1;
    end

    assign echo_free = (o_cipher_letter != r_letter_q2);

    // handshake: result held while stalled
    `TRRC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `TRRC_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_cipher_letter))

    // input backpressure only comes from a stalled, full output
    `TRRC_ASSERT_NOW(a_stall_origin, o_in_stall, o_out_valid && i_out_stall)

    // an accepted encode is valid at the output unless stalled; the reflector never maps a letter to itself
    `TRRC_ASSERT_NEXT(a_latency_nofix, enc_accept ##1 !i_out_stall, o_out_valid && echo_free)

endmodule

bind three_rotor_reflector_cipher_top trrc_checker u_trrc_checker (.*);
